[rtl/core/mbcd_pkg.sv]
// mbcd_pkg: shared types, codes, the note frequency table and constant-divide helper
// for the midi byte command decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbcd_pkg;

    // widths of the payload fields
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DATA_W     = 7;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned FREQ_W     = 22;
    localparam int unsigned VOLUME_W   = 7;
    localparam int unsigned WAVE_W     = 2;
    localparam int unsigned RATIO_W    = 12;
    localparam int unsigned FILTER_W   = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;

    // table entries are Q8 Hz
    localparam int unsigned FREQ_ROM_FRAC     = 8;
    localparam int unsigned FREQ_FRAC_BITS_DEF = 8;

    // status nibbles
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_CC       = 4'hB;

    // filter value that passes every channel
    localparam logic [FILTER_W-1:0] FILTER_ALL = 5'h1F;

    // reset values of the configuration registers
    localparam logic [DATA_W-1:0] CC_VOLUME_DEF   = 7'd7;
    localparam logic [DATA_W-1:0] CC_WAVEFORM_DEF = 7'd70;
    localparam logic [DATA_W-1:0] CC_CAPTURE_DEF  = 7'd71;
    localparam logic [DATA_W-1:0] CC_RATIO_DEF    = 7'd72;

    // scaling constants
    localparam logic [13:0]        VOLUME_MUL = 14'd100;
    localparam logic [RATIO_W-1:0] RATIO_MUL  = 12'd18;
    localparam logic [RATIO_W-1:0] RATIO_BASE = 12'd256;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_FILTER = 3'd0,
        REG_CC_VOLUME      = 3'd1,
        REG_CC_WAVEFORM    = 3'd2,
        REG_CC_CAPTURE     = 3'd3,
        REG_CC_RATIO       = 3'd4
    } cfg_reg_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        EVT_NOTE_ON  = 3'd0,
        EVT_NOTE_OFF = 3'd1,
        EVT_VOLUME   = 3'd2,
        EVT_WAVEFORM = 3'd3,
        EVT_CAPTURE  = 3'd4,
        EVT_RATIO    = 3'd5
    } event_kind_t;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DATA1 = 3'b010,
        PH_DATA2 = 3'b100
    } parse_phase_t;

    // floor(x / 127) for x where (x mod 128) + (x / 128) stays below 254
    function automatic logic [6:0] div_by_127(input logic [13:0] x);
        logic [6:0] q0;
        logic [7:0] rem;
        begin
            q0  = x[13:7];
            rem = {1'b0, x[6:0]} + {1'b0, q0};
            return (rem >= 8'd127) ? q0 + 7'd1 : q0;
        end
    endfunction

    // note frequency in Q8 Hz, equal temperament around a4 = 440 Hz
    function automatic logic [FREQ_W-1:0] note_freq_q8(input logic [DATA_W-1:0] note);
        logic [FREQ_W-1:0] f;
        begin
            case (note)
                7'd0: f = 22'd2093;       7'd1: f = 22'd2217;
                7'd2: f = 22'd2349;       7'd3: f = 22'd2489;
                7'd4: f = 22'd2637;       7'd5: f = 22'd2793;
                7'd6: f = 22'd2959;       7'd7: f = 22'd3135;
                7'd8: f = 22'd3322;       7'd9: f = 22'd3520;
                7'd10: f = 22'd3729;      7'd11: f = 22'd3951;
                7'd12: f = 22'd4186;      7'd13: f = 22'd4434;
                7'd14: f = 22'd4698;      7'd15: f = 22'd4978;
                7'd16: f = 22'd5274;      7'd17: f = 22'd5587;
                7'd18: f = 22'd5919;      7'd19: f = 22'd6271;
                7'd20: f = 22'd6644;      7'd21: f = 22'd7040;
                7'd22: f = 22'd7458;      7'd23: f = 22'd7902;
                7'd24: f = 22'd8372;      7'd25: f = 22'd8869;
                7'd26: f = 22'd9397;      7'd27: f = 22'd9956;
                7'd28: f = 22'd10548;     7'd29: f = 22'd11175;
                7'd30: f = 22'd11839;     7'd31: f = 22'd12543;
                7'd32: f = 22'd13289;     7'd33: f = 22'd14080;
                7'd34: f = 22'd14917;     7'd35: f = 22'd15804;
                7'd36: f = 22'd16744;     7'd37: f = 22'd17739;
                7'd38: f = 22'd18794;     7'd39: f = 22'd19912;
                7'd40: f = 22'd21096;     7'd41: f = 22'd22350;
                7'd42: f = 22'd23679;     7'd43: f = 22'd25087;
                7'd44: f = 22'd26579;     7'd45: f = 22'd28160;
                7'd46: f = 22'd29834;     7'd47: f = 22'd31608;
                7'd48: f = 22'd33488;     7'd49: f = 22'd35479;
                7'd50: f = 22'd37589;     7'd51: f = 22'd39824;
                7'd52: f = 22'd42192;     7'd53: f = 22'd44701;
                7'd54: f = 22'd47359;     7'd55: f = 22'd50175;
                7'd56: f = 22'd53159;     7'd57: f = 22'd56320;
                7'd58: f = 22'd59668;     7'd59: f = 22'd63217;
                7'd60: f = 22'd66976;     7'd61: f = 22'd70958;
                7'd62: f = 22'd75178;     7'd63: f = 22'd79648;
                7'd64: f = 22'd84384;     7'd65: f = 22'd89402;
                7'd66: f = 22'd94718;     7'd67: f = 22'd100350;
                7'd68: f = 22'd106318;    7'd69: f = 22'd112640;
                7'd70: f = 22'd119337;    7'd71: f = 22'd126434;
                7'd72: f = 22'd133952;    7'd73: f = 22'd141917;
                7'd74: f = 22'd150356;    7'd75: f = 22'd159297;
                7'd76: f = 22'd168769;    7'd77: f = 22'd178804;
                7'd78: f = 22'd189437;    7'd79: f = 22'd200701;
                7'd80: f = 22'd212636;    7'd81: f = 22'd225280;
                7'd82: f = 22'd238675;    7'd83: f = 22'd252868;
                7'd84: f = 22'd267904;    7'd85: f = 22'd283835;
                7'd86: f = 22'd300712;    7'd87: f = 22'd318594;
                7'd88: f = 22'd337538;    7'd89: f = 22'd357609;
                7'd90: f = 22'd378874;    7'd91: f = 22'd401403;
                7'd92: f = 22'd425272;    7'd93: f = 22'd450560;
                7'd94: f = 22'd477351;    7'd95: f = 22'd505736;
                7'd96: f = 22'd535809;    7'd97: f = 22'd567670;
                7'd98: f = 22'd601425;    7'd99: f = 22'd637188;
                7'd100: f = 22'd675077;   7'd101: f = 22'd715219;
                7'd102: f = 22'd757748;   7'd103: f = 22'd802806;
                7'd104: f = 22'd850544;   7'd105: f = 22'd901120;
                7'd106: f = 22'd954703;   7'd107: f = 22'd1011473;
                7'd108: f = 22'd1071618;  7'd109: f = 22'd1135340;
                7'd110: f = 22'd1202850;  7'd111: f = 22'd1274376;
                7'd112: f = 22'd1350154;  7'd113: f = 22'd1430438;
                7'd114: f = 22'd1515497;  7'd115: f = 22'd1605613;
                7'd116: f = 22'd1701088;  7'd117: f = 22'd1802240;
                7'd118: f = 22'd1909406;  7'd119: f = 22'd2022946;
                7'd120: f = 22'd2143236;  7'd121: f = 22'd2270680;
                7'd122: f = 22'd2405701;  7'd123: f = 22'd2548752;
                7'd124: f = 22'd2700308;  7'd125: f = 22'd2860877;
                7'd126: f = 22'd3030994;  7'd127: f = 22'd3211226;
                default: f = '0;
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/mbcd_ifs.sv]
// mbcd channel interfaces: received byte stream, decoded event stream and
// configuration write channel. Depends on mbcd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbcd_byte_if;
    logic                              valid;
    logic                              ready;
    logic [mbcd_pkg::BYTE_W-1:0]       rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbcd_event_if;
    logic                              valid;
    logic                              ready;
    logic [mbcd_pkg::KIND_W-1:0]       event_kind;
    logic [mbcd_pkg::DATA_W-1:0]       note_number;
    logic [mbcd_pkg::FREQ_W-1:0]       note_frequency;
    logic [mbcd_pkg::VOLUME_W-1:0]     volume_level;
    logic [mbcd_pkg::WAVE_W-1:0]       waveform_select;
    logic [mbcd_pkg::RATIO_W-1:0]      ratio_value;

    modport source (output valid, output event_kind, output note_number,
                    output note_frequency, output volume_level,
                    output waveform_select, output ratio_value, input ready);
    modport sink   (input valid, input event_kind, input note_number,
                    input note_frequency, input volume_level,
                    input waveform_select, input ratio_value, output ready);
endinterface

interface mbcd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mbcd_pkg::CFG_IDX_W-1:0]    index;
    logic [mbcd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/midi_byte_command_decoder.sv]
// midi_byte_command_decoder: top level, byte parser, channel filter, event decode
// and output register. Depends on mbcd_pkg and the interfaces in mbcd_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one MIDI byte per clock on rx and emits at most one decoded event per
// message on evt. A status byte (bit 7 set) starts a message; the second data
// byte after it completes the message, and the event appears on evt in the cycle
// after that byte's transfer, from a single output register. Data bytes seen
// while idle are dropped, and there is no running status. rx accepts a byte
// every cycle while the output register is empty or being drained, so the
// sustained rate is one byte per cycle; it only stalls while an event waits
// on evt. Configuration writes on cfg are always accepted and take effect on
// the next byte. FREQ_FRAC_BITS sets the fractional bits of note_frequency.
module midi_byte_command_decoder #(
    parameter int unsigned FREQ_FRAC_BITS = mbcd_pkg::FREQ_FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mbcd_byte_if.sink          rx,
    mbcd_event_if.source       evt,
    mbcd_cfg_if.sink           cfg
);

    localparam int unsigned FREQ_SHL =
        (FREQ_FRAC_BITS >= mbcd_pkg::FREQ_ROM_FRAC) ?
        FREQ_FRAC_BITS - mbcd_pkg::FREQ_ROM_FRAC : 0;
    localparam int unsigned FREQ_SHR =
        (FREQ_FRAC_BITS >= mbcd_pkg::FREQ_ROM_FRAC) ?
        0 : mbcd_pkg::FREQ_ROM_FRAC - FREQ_FRAC_BITS;

    // configuration registers
    logic [mbcd_pkg::FILTER_W-1:0]   filter_reg;
    logic [mbcd_pkg::DATA_W-1:0]     cc_volume_reg;
    logic [mbcd_pkg::DATA_W-1:0]     cc_waveform_reg;
    logic [mbcd_pkg::DATA_W-1:0]     cc_capture_reg;
    logic [mbcd_pkg::DATA_W-1:0]     cc_ratio_reg;

    // parser state
    mbcd_pkg::parse_phase_t          phase_reg;
    mbcd_pkg::parse_phase_t          phase_next;
    logic [mbcd_pkg::BYTE_W-1:0]     status_reg;
    logic [mbcd_pkg::DATA_W-1:0]     first_data_reg;

    // output register
    logic                            out_valid_reg;
    mbcd_pkg::event_kind_t           kind_reg;
    logic [mbcd_pkg::DATA_W-1:0]     note_reg;
    logic [mbcd_pkg::FREQ_W-1:0]     freq_reg;
    logic [mbcd_pkg::VOLUME_W-1:0]   volume_reg;
    logic [mbcd_pkg::WAVE_W-1:0]     wave_reg;
    logic [mbcd_pkg::RATIO_W-1:0]    ratio_reg;

    // decode results
    logic                            rx_xfer;
    logic                            is_status;
    logic                            msg_done;
    logic                            chan_ok;
    logic                            hit;
    logic [3:0]                      cmd;
    logic [3:0]                      chan;
    logic [mbcd_pkg::DATA_W-1:0]     d1;
    logic [mbcd_pkg::DATA_W-1:0]     d2;
    logic [13:0]                     vol_prod;
    logic [mbcd_pkg::RATIO_W-1:0]    ratio_prod;
    logic [6:0]                      ratio_quot;
    logic [mbcd_pkg::FREQ_W-1:0]     rom_freq;
    mbcd_pkg::event_kind_t           kind_next;
    logic [mbcd_pkg::FREQ_W-1:0]     freq_next;
    logic [mbcd_pkg::VOLUME_W-1:0]   volume_next;
    logic [mbcd_pkg::WAVE_W-1:0]     wave_next;
    logic [mbcd_pkg::RATIO_W-1:0]    ratio_next;

    // handshakes
    assign cfg.ready = 1'b1;
    assign rx.ready  = !out_valid_reg || evt.ready;
    assign rx_xfer   = rx.valid && rx.ready;
    assign is_status = rx.rx_byte[mbcd_pkg::BYTE_W-1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg      <= mbcd_pkg::FILTER_ALL;
            cc_volume_reg   <= mbcd_pkg::CC_VOLUME_DEF;
            cc_waveform_reg <= mbcd_pkg::CC_WAVEFORM_DEF;
            cc_capture_reg  <= mbcd_pkg::CC_CAPTURE_DEF;
            cc_ratio_reg    <= mbcd_pkg::CC_RATIO_DEF;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mbcd_pkg::REG_CHANNEL_FILTER: filter_reg <= cfg.data[mbcd_pkg::FILTER_W-1:0];
                mbcd_pkg::REG_CC_VOLUME:      cc_volume_reg   <= cfg.data;
                mbcd_pkg::REG_CC_WAVEFORM:    cc_waveform_reg <= cfg.data;
                mbcd_pkg::REG_CC_CAPTURE:     cc_capture_reg  <= cfg.data;
                mbcd_pkg::REG_CC_RATIO:       cc_ratio_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    // parser phase
    always_comb
    begin
        phase_next = phase_reg;
        msg_done   = 1'b0;
        if (rx_xfer)
        begin
            if (is_status)
            begin
                phase_next = mbcd_pkg::PH_DATA1;
            end
            else
            begin
                unique case (phase_reg)
                    mbcd_pkg::PH_DATA1: phase_next = mbcd_pkg::PH_DATA2;
                    mbcd_pkg::PH_DATA2:
                    begin
                        phase_next = mbcd_pkg::PH_IDLE;
                        msg_done   = 1'b1;
                    end
                    default: phase_next = mbcd_pkg::PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mbcd_pkg::PH_IDLE;
            status_reg     <= '0;
            first_data_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (rx_xfer && is_status)
            begin
                status_reg <= rx.rx_byte;
            end
            if (rx_xfer && !is_status && phase_reg == mbcd_pkg::PH_DATA1)
            begin
                first_data_reg <= rx.rx_byte[mbcd_pkg::DATA_W-1:0];
            end
        end
    end

    // message fields and channel filter
    assign cmd     = status_reg[7:4];
    assign chan    = status_reg[3:0];
    assign d1      = first_data_reg;
    assign d2      = rx.rx_byte[mbcd_pkg::DATA_W-1:0];
    assign chan_ok = (filter_reg == mbcd_pkg::FILTER_ALL) ||
                     (!filter_reg[mbcd_pkg::FILTER_W-1] &&
                      chan == filter_reg[3:0]);

    // constant scaling: volume d2*100/127, ratio 256 + d2*18*128/127
    assign vol_prod   = 14'(d2) * mbcd_pkg::VOLUME_MUL;
    assign ratio_prod = 12'(d2) * mbcd_pkg::RATIO_MUL;
    assign ratio_quot = mbcd_pkg::div_by_127({2'b00, ratio_prod});

    // note frequency table and fraction alignment
    assign rom_freq = mbcd_pkg::note_freq_q8(d1);

    // event decode
    always_comb
    begin
        hit         = 1'b0;
        kind_next   = mbcd_pkg::EVT_NOTE_OFF;
        freq_next   = '0;
        volume_next = '0;
        wave_next   = '0;
        ratio_next  = '0;
        if (cmd == mbcd_pkg::CMD_NOTE_ON || cmd == mbcd_pkg::CMD_NOTE_OFF)
        begin
            hit = 1'b1;
            if (cmd == mbcd_pkg::CMD_NOTE_ON && d2 != '0)
            begin
                kind_next = mbcd_pkg::EVT_NOTE_ON;
                if (FREQ_FRAC_BITS >= mbcd_pkg::FREQ_ROM_FRAC)
                begin
                    freq_next = rom_freq << FREQ_SHL;
                end
                else
                begin
                    freq_next = rom_freq >> FREQ_SHR;
                end
            end
        end
        else if (cmd == mbcd_pkg::CMD_CC)
        begin
            // controller numbers in priority order
            if (d1 == cc_volume_reg)
            begin
                hit         = 1'b1;
                kind_next   = mbcd_pkg::EVT_VOLUME;
                volume_next = mbcd_pkg::div_by_127(vol_prod);
            end
            else if (d1 == cc_waveform_reg)
            begin
                hit       = 1'b1;
                kind_next = mbcd_pkg::EVT_WAVEFORM;
                wave_next = d2[6:5];
            end
            else if (d1 == cc_capture_reg)
            begin
                hit       = (d2 != '0);
                kind_next = mbcd_pkg::EVT_CAPTURE;
            end
            else if (d1 == cc_ratio_reg)
            begin
                hit        = 1'b1;
                kind_next  = mbcd_pkg::EVT_RATIO;
                ratio_next = mbcd_pkg::RATIO_BASE + ratio_prod +
                             mbcd_pkg::RATIO_W'(ratio_quot);
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (msg_done && chan_ok && hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (msg_done && chan_ok && hit)
        begin
            kind_reg   <= kind_next;
            note_reg   <= (kind_next == mbcd_pkg::EVT_NOTE_ON ||
                           kind_next == mbcd_pkg::EVT_NOTE_OFF) ? d1 : '0;
            freq_reg   <= freq_next;
            volume_reg <= volume_next;
            wave_reg   <= wave_next;
            ratio_reg  <= ratio_next;
        end
    end

    assign evt.valid           = out_valid_reg;
    assign evt.event_kind      = kind_reg;
    assign evt.note_number     = note_reg;
    assign evt.note_frequency  = freq_reg;
    assign evt.volume_level    = volume_reg;
    assign evt.waveform_select = wave_reg;
    assign evt.ratio_value     = ratio_reg;

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for midi_byte_command_decoder: drives byte streams, predicts decoded
// events from its own model of the parser and checks every event on evt.
// Depends on mbcd_pkg, the channel interfaces in mbcd_ifs.sv and the decoder top.
`timescale 1ns / 1ps

module testbench;

    import mbcd_pkg::*;

    localparam int HOLDOFF_CYCLES = 200;
    localparam int RUN_LIMIT_NS   = 10_000_000;

    // status nibbles and system range that decode to no event
    localparam logic [3:0]        CMD_POLY_PRESSURE = 4'hA;
    localparam logic [3:0]        CMD_PROGRAM       = 4'hC;
    localparam logic [3:0]        CMD_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0]        CMD_PITCH_BEND    = 4'hE;
    localparam logic [BYTE_W-1:0] SYSTEM_FIRST      = 8'hF0;
    localparam logic [BYTE_W-1:0] STATUS_FIRST      = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_LAST       = 8'hFF;

    typedef struct packed {
        event_kind_t         kind;
        logic [DATA_W-1:0]   note;
        logic [FREQ_W-1:0]   freq;
        logic [VOLUME_W-1:0] volume;
        logic [WAVE_W-1:0]   wave;
        logic [RATIO_W-1:0]  ratio;
    } midi_event_t;

    logic clk;
    logic rst_n;

    mbcd_byte_if  rx_if ();
    mbcd_event_if evt_if ();
    mbcd_cfg_if   cfg_if ();

    midi_byte_command_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .evt   (evt_if),
        .cfg   (cfg_if)
    );

    // decoder model state and register copies
    logic [FILTER_W-1:0] filter_q;
    logic [DATA_W-1:0]   cc_volume_q;
    logic [DATA_W-1:0]   cc_waveform_q;
    logic [DATA_W-1:0]   cc_capture_q;
    logic [DATA_W-1:0]   cc_ratio_q;
    parse_phase_t        parse_phase_q;
    logic [BYTE_W-1:0]   held_status_q;
    logic [DATA_W-1:0]   held_data_q;
    logic [FREQ_W-1:0]   pitch_table_q8 [128];

    midi_event_t pending_events [$];
    int          mismatch_count;
    int          bytes_sent;
    bit          no_gaps;
    bit          holdoff_req;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // equal temperament around a4 = 440 Hz, floor in Q8
    task automatic build_pitch_table();
        real hz;
        for (int n = 0; n < 128; n++)
        begin
            hz = 440.0 * (2.0 ** ((real'(n) - 69.0) / 12.0)) * 256.0;
            pitch_table_q8[n] = FREQ_W'($rtoi(hz + 1.0e-6));
        end
    endtask

    // advance the parser model by one accepted byte, queue any event it yields
    task automatic decode_midi_byte(input logic [BYTE_W-1:0] b);
        midi_event_t ev;
        logic [DATA_W-1:0] d2;
        bit emit;
        ev   = '0;
        emit = 1'b0;
        d2   = b[DATA_W-1:0];
        if (b[7])
        begin
            held_status_q = b;
            parse_phase_q = PH_DATA1;
        end
        else if (parse_phase_q == PH_DATA1)
        begin
            held_data_q   = d2;
            parse_phase_q = PH_DATA2;
        end
        else if (parse_phase_q == PH_DATA2)
        begin
            parse_phase_q = PH_IDLE;
            if (filter_q == FILTER_ALL ||
                (!filter_q[4] && held_status_q[3:0] == filter_q[3:0]))
            begin
                case (held_status_q[7:4])
                    CMD_NOTE_ON, CMD_NOTE_OFF:
                    begin
                        emit    = 1'b1;
                        ev.note = held_data_q;
                        if (held_status_q[7:4] == CMD_NOTE_ON && d2 != 0)
                        begin
                            ev.kind = EVT_NOTE_ON;
                            ev.freq = pitch_table_q8[held_data_q];
                        end
                        else
                            ev.kind = EVT_NOTE_OFF;
                    end
                    CMD_CC:
                    begin
                        // controller numbers matched in priority order
                        if (held_data_q == cc_volume_q)
                        begin
                            emit      = 1'b1;
                            ev.kind   = EVT_VOLUME;
                            ev.volume = VOLUME_W'((int'(d2) * 100) / 127);
                        end
                        else if (held_data_q == cc_waveform_q)
                        begin
                            emit    = 1'b1;
                            ev.kind = EVT_WAVEFORM;
                            ev.wave = d2[6:5];
                        end
                        else if (held_data_q == cc_capture_q)
                        begin
                            emit    = (d2 != 0);
                            ev.kind = EVT_CAPTURE;
                        end
                        else if (held_data_q == cc_ratio_q)
                        begin
                            emit     = 1'b1;
                            ev.kind  = EVT_RATIO;
                            ev.ratio = RATIO_W'(256 + (int'(d2) * 2304) / 127);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
            parse_phase_q = PH_IDLE;
        if (emit)
            pending_events.push_back(ev);
    endtask

    // one byte transfer on rx, with an optional idle gap before it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        decode_midi_byte(b);
        bytes_sent++;
    endtask

    // stop offering bytes and wait until every predicted event has come out
    task automatic settle_block();
        rx_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write transfer; valid is left high for back-to-back writes
    task automatic cfg_transfer(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        case (idx)
            REG_CHANNEL_FILTER: filter_q      = val[FILTER_W-1:0];
            REG_CC_VOLUME:      cc_volume_q   = val;
            REG_CC_WAVEFORM:    cc_waveform_q = val;
            REG_CC_CAPTURE:     cc_capture_q  = val;
            REG_CC_RATIO:       cc_ratio_q    = val;
            default:
            begin
            end
        endcase
    endtask

    // write all five registers while the block is idle
    task automatic program_registers(input logic [FILTER_W-1:0] filt,
                                     input logic [DATA_W-1:0] vol,
                                     input logic [DATA_W-1:0] wave,
                                     input logic [DATA_W-1:0] cap,
                                     input logic [DATA_W-1:0] ratio);
        settle_block();
        // filter is sign extended onto the write data
        cfg_transfer(REG_CHANNEL_FILTER, {{(CFG_DATA_W - FILTER_W){filt[4]}}, filt});
        cfg_transfer(REG_CC_VOLUME, vol);
        cfg_transfer(REG_CC_WAVEFORM, wave);
        cfg_transfer(REG_CC_CAPTURE, cap);
        cfg_transfer(REG_CC_RATIO, ratio);
        cfg_if.valid <= 1'b0;
    endtask

    // data byte biased toward its extremes
    function automatic logic [DATA_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return DATA_W'($urandom_range(0, 127));
    endfunction

    // one message of random shape: mostly well formed, some broken, some noise
    task automatic send_random_message();
        int r;
        int sel;
        logic [3:0] ch;
        logic [DATA_W-1:0] d1;
        r  = $urandom_range(0, 99);
        ch = 4'($urandom_range(0, 15));
        if (!filter_q[4] && $urandom_range(0, 9) < 7)
            ch = filter_q[3:0];
        if (r < 30)
        begin
            send_byte({CMD_NOTE_ON, ch});
            send_byte({1'b0, pick_data()});
            send_byte({1'b0, pick_data()});
        end
        else if (r < 45)
        begin
            send_byte({CMD_NOTE_OFF, ch});
            send_byte({1'b0, pick_data()});
            send_byte({1'b0, pick_data()});
        end
        else if (r < 75)
        begin
            // controller number mostly one of the configured ones
            sel = $urandom_range(0, 4);
            case (sel)
                0:       d1 = cc_volume_q;
                1:       d1 = cc_waveform_q;
                2:       d1 = cc_capture_q;
                3:       d1 = cc_ratio_q;
                default: d1 = pick_data();
            endcase
            send_byte({CMD_CC, ch});
            send_byte({1'b0, d1});
            send_byte({1'b0, pick_data()});
        end
        else if (r < 85)
        begin
            // aftertouch, program, pressure, bend or system: no event
            sel = $urandom_range(0, 4);
            case (sel)
                0:       send_byte({CMD_POLY_PRESSURE, ch});
                1:       send_byte({CMD_PROGRAM, ch});
                2:       send_byte({CMD_CHAN_PRESSURE, ch});
                3:       send_byte({CMD_PITCH_BEND, ch});
                default: send_byte(BYTE_W'($urandom_range(SYSTEM_FIRST, STATUS_LAST)));
            endcase
            send_byte({1'b0, pick_data()});
            send_byte({1'b0, pick_data()});
        end
        else if (r < 93)
        begin
            // cut short, the next status restarts the parser
            send_byte(BYTE_W'($urandom_range(STATUS_FIRST, STATUS_LAST)));
            if ($urandom_range(0, 1) == 1)
                send_byte({1'b0, pick_data()});
        end
        else
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_messages(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_random_message();
    endtask

    // fixed messages under reset register values
    task automatic test_decode_directed();
        logic [BYTE_W-1:0] seq [$];
        seq = '{8'h90, 8'h00, 8'h7F,             // note on, lowest note, top velocity
                8'h9F, 8'h7F, 8'h01,             // note on, highest note, channel 15
                8'h95, 8'h3C, 8'h00,             // note on with zero velocity
                8'h80, 8'h45, 8'h40,             // note off
                8'hB0, 8'h07, 8'h7F,             // full volume
                8'hB3, 8'h46, 8'h60,             // waveform select
                8'hB0, 8'h47, 8'h00,             // capture with zero value
                8'hB0, 8'h47, 8'h01,             // capture
                8'hBF, 8'h48, 8'h7F,             // top ratio
                8'h7F,                           // data while idle
                8'h90, 8'h40, 8'hF8, 8'h10, 8'h20, // real-time byte mid-message
                8'hE0, 8'h00, 8'h40};            // pitch bend
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // each filter setting, the negative ones that match nothing among them
    task automatic test_channel_filter();
        logic [FILTER_W-1:0] filters [$];
        filters = '{5'h00, 5'h0F, 5'h10, 5'h1E, 5'h09, FILTER_ALL};
        foreach (filters[i])
        begin
            program_registers(filters[i], cc_volume_q, cc_waveform_q,
                              cc_capture_q, cc_ratio_q);
            send_messages(60);
        end
    endtask

    // extreme and duplicated controller numbers
    task automatic test_controller_numbers();
        program_registers(FILTER_ALL, 7'd0, 7'd127, 7'd1, 7'd126);
        send_messages(60);
        program_registers(FILTER_ALL, 7'd9, 7'd9, 7'd9, 7'd9);
        send_messages(60);
        program_registers(FILTER_ALL, 7'd5, 7'd6, 7'd8, 7'd8);
        send_messages(60);
    endtask

    // receiver holds off while notes keep coming, so rx must stall
    task automatic test_backpressure();
        settle_block();
        no_gaps     = 1'b1;
        holdoff_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_byte({CMD_NOTE_ON, 4'($urandom_range(0, 15))});
            send_byte({1'b0, pick_data()});
            send_byte(8'($urandom_range(1, 127)));
        end
        no_gaps = 1'b0;
    endtask

    // random register settings, mixed traffic, some stretches without idling
    task automatic test_random_traffic();
        int r;
        logic [FILTER_W-1:0] filt;
        logic [DATA_W-1:0] nums [4];
        for (int phase = 0; phase < 8; phase++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                filt = FILTER_ALL;
            else if (r < 85)
                filt = 5'($urandom_range(0, 15));
            else
                filt = 5'($urandom_range(16, 30));
            foreach (nums[i])
            begin
                nums[i] = DATA_W'($urandom_range(0, 127));
                if (i > 0 && $urandom_range(0, 3) == 0)
                    nums[i] = nums[$urandom_range(0, i - 1)];
            end
            program_registers(filt, nums[0], nums[1], nums[2], nums[3]);
            no_gaps = (phase % 3 == 2);
            send_messages(90);
        end
        no_gaps = 1'b0;
    endtask

    // event receiver: random stalls and the long hold-off
    initial
    begin
        int stall_left;
        int gap;
        stall_left = 0;
        evt_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                evt_if.ready <= 1'b0;
            end
            else if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                stall_left  = HOLDOFF_CYCLES - 1;
                evt_if.ready <= 1'b0;
            end
            else if (!no_gaps && $urandom_range(0, 3) == 0)
            begin
                gap = pick_gap();
                if (gap > 0)
                    stall_left = gap - 1;
                evt_if.ready <= (gap == 0);
            end
            else
                evt_if.ready <= 1'b1;
        end
    end

    // compare each event transfer with the oldest prediction
    always @(posedge clk)
    begin
        midi_event_t want;
        if (rst_n === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1)
        begin
            if (pending_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected event: kind=%0d note=%0d freq=%0d",
                             evt_if.event_kind, evt_if.note_number,
                             evt_if.note_frequency);
            end
            else
            begin
                want = pending_events.pop_front();
                if (evt_if.event_kind !== want.kind ||
                    evt_if.note_number !== want.note ||
                    evt_if.note_frequency !== want.freq ||
                    evt_if.volume_level !== want.volume ||
                    evt_if.waveform_select !== want.wave ||
                    evt_if.ratio_value !== want.ratio)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"event mismatch: expected kind=%0d note=%0d freq=%0d",
                                  " vol=%0d wave=%0d ratio=%0d, got kind=%0d note=%0d",
                                  " freq=%0d vol=%0d wave=%0d ratio=%0d"},
                                 want.kind, want.note, want.freq, want.volume,
                                 want.wave, want.ratio, evt_if.event_kind,
                                 evt_if.note_number, evt_if.note_frequency,
                                 evt_if.volume_level, evt_if.waveform_select,
                                 evt_if.ratio_value);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // reset, then the tests in turn
    initial
    begin
        rst_n          <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_CHANNEL_FILTER;
        cfg_if.data    <= '0;
        mismatch_count = 0;
        bytes_sent     = 0;
        no_gaps        = 1'b0;
        holdoff_req    = 1'b0;
        filter_q       = FILTER_ALL;
        cc_volume_q    = CC_VOLUME_DEF;
        cc_waveform_q  = CC_WAVEFORM_DEF;
        cc_capture_q   = CC_CAPTURE_DEF;
        cc_ratio_q     = CC_RATIO_DEF;
        parse_phase_q  = PH_IDLE;
        held_status_q  = '0;
        held_data_q    = '0;
        build_pitch_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_decode_directed();
        test_channel_filter();
        test_controller_numbers();
        test_backpressure();
        test_random_traffic();

        settle_block();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/mbcd_pkg.sv
rtl/core/mbcd_ifs.sv
rtl/core/midi_byte_command_decoder.sv
verif/testbench.sv
